// ----- sv/u8d_pkg.sv -----
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types for the UTF-8 stream decoder: status codes, decoder state and
// result word layout.
// ----------------------------------------------------------------------------
package u8d_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 31;
  localparam int unsigned CountW = 3;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_LEAD = 2'd1,
    ST_BAD_CONT = 2'd2
  } status_t;

  typedef struct packed {
    logic [CountW-1:0] bytes_remaining;
    logic [CountW-1:0] bytes_taken;
    logic [CpW-1:0]    partial_value;
  } dec_state_t;

  typedef struct packed {
    logic              valid;
    logic [CpW-1:0]    code_point;
    logic [CountW-1:0] seq_length;
    status_t           status;
  } dec_result_t;

endpackage

// ----- sv/u8d_step.sv -----
// ----------------------------------------------------------------------------
// u8d_step
// One decoder step: given the current state and one byte, forms the next
// state and at most one result word.
// ----------------------------------------------------------------------------
module u8d_step (
  input  u8d_pkg::dec_state_t  cur,
  input  logic [7:0]           data_byte,
  output u8d_pkg::dec_state_t  nxt,
  output u8d_pkg::dec_result_t res
);

  import u8d_pkg::*;

  localparam dec_state_t Idle = '0;

  always_comb begin
    nxt = cur;
    res = '0;
    res.status = ST_OK;
    if (cur.bytes_remaining == '0) begin
      nxt = Idle;
      unique case (data_byte) inside
        8'b0???????: begin
          res.valid      = 1'b1;
          res.code_point = {{(CpW-ByteW){1'b0}}, data_byte};
          res.seq_length = CountW'(1);
        end
        8'b110?????: begin
          nxt.bytes_remaining = CountW'(1);
          nxt.bytes_taken     = CountW'(1);
          nxt.partial_value   = {{(CpW-5){1'b0}}, data_byte[4:0]};
        end
        8'b1110????: begin
          nxt.bytes_remaining = CountW'(2);
          nxt.bytes_taken     = CountW'(1);
          nxt.partial_value   = {{(CpW-4){1'b0}}, data_byte[3:0]};
        end
        8'b11110???: begin
          nxt.bytes_remaining = CountW'(3);
          nxt.bytes_taken     = CountW'(1);
          nxt.partial_value   = {{(CpW-3){1'b0}}, data_byte[2:0]};
        end
        8'b111110??: begin
          nxt.bytes_remaining = CountW'(4);
          nxt.bytes_taken     = CountW'(1);
          nxt.partial_value   = {{(CpW-2){1'b0}}, data_byte[1:0]};
        end
        8'b1111110?: begin
          nxt.bytes_remaining = CountW'(5);
          nxt.bytes_taken     = CountW'(1);
          nxt.partial_value   = {{(CpW-1){1'b0}}, data_byte[0]};
        end
        default: begin
          // stray continuation, 0xFE or 0xFF
          res.valid      = 1'b1;
          res.seq_length = CountW'(1);
          res.status     = ST_BAD_LEAD;
        end
      endcase
    end else if (data_byte[7:6] != 2'b10) begin
      nxt            = Idle;
      res.valid      = 1'b1;
      res.seq_length = cur.bytes_taken + CountW'(1);
      res.status     = ST_BAD_CONT;
    end else begin
      nxt.partial_value   = {cur.partial_value[CpW-7:0], data_byte[5:0]};
      nxt.bytes_taken     = cur.bytes_taken + CountW'(1);
      nxt.bytes_remaining = cur.bytes_remaining - CountW'(1);
      if (cur.bytes_remaining == CountW'(1)) begin
        res.valid      = 1'b1;
        res.code_point = nxt.partial_value;
        res.seq_length = nxt.bytes_taken;
        nxt            = Idle;
      end
    end
  end

endmodule

// ----- sv/utf8_stream_decoder_core.sv -----
// ----------------------------------------------------------------------------
// utf8_stream_decoder_core
// Streaming RFC 2279 UTF-8 decoder, one to six bytes per sequence, 31-bit
// code points out.
// ----------------------------------------------------------------------------
// Takes one byte per cycle; the input stalls only while a byte waits in the
// input register and a result word is held by out_stall. Each byte passes an
// input register, one decode step and a result register; a result word is
// registered as its last byte leaves the input register, and one is issued
// only when a sequence completes or fails; overlong forms are passed through.
// On an error the partial sequence and the offending byte are dropped and
// decoding restarts from idle.
module utf8_stream_decoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [30:0] code_point,
  output logic [2:0]  seq_length,
  output logic [1:0]  status
);

  import u8d_pkg::*;

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_move;
  dec_state_t  st;
  dec_state_t  st_next;
  dec_result_t res;
  dec_result_t out_word;

  assign s1_move  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_move;

  u8d_step u_step (
    .cur       (st),
    .data_byte (s1_byte),
    .nxt       (st_next),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_byte <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (s1_move) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= s1_move && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && res.valid) begin
      out_word <= res;
    end
  end

  assign code_point = out_word.code_point;
  assign seq_length = out_word.seq_length;
  assign status     = out_word.status;

  a_err_zero_cp: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> code_point == '0)
    else $error("error word carries a nonzero code point");

  a_bad_lead_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_BAD_LEAD |-> seq_length == 3'd1)
    else $error("invalid lead word with length other than one");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> seq_length != 3'd0 && seq_length != 3'd7)
    else $error("sequence length out of range");

  a_state_sane: assert property (@(posedge clk) disable iff (rst)
    st.bytes_remaining != '0 |-> st.bytes_taken != '0 &&
      (st.bytes_remaining + st.bytes_taken) <= 3'd6)
    else $error("decoder counts inconsistent");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled without a blocked result");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stream test for the UTF-8 decoder core: drives byte words with random gaps
// and output stalls, predicts each code point or error report from its own
// model of the decode state, and checks every result word field by field.
// ----------------------------------------------------------------------------

import u8d_pkg::*;

class decode_checker;
  logic [2:0]  cont_left;
  logic [2:0]  seq_bytes;
  logic [30:0] acc;
  dec_result_t pending_chars[$];
  int          mismatches;
  int          chars_by_len[7];
  int          lead_errs;
  int          cont_errs;

  function new();
    cont_left  = '0;
    seq_bytes  = '0;
    acc        = '0;
    mismatches = 0;
    lead_errs  = 0;
    cont_errs  = 0;
    foreach (chars_by_len[i]) chars_by_len[i] = 0;
  endfunction

  function void push_char(logic [30:0] cp, logic [2:0] len, status_t st);
    dec_result_t r;
    r.valid      = 1'b1;
    r.code_point = cp;
    r.seq_length = len;
    r.status     = st;
    pending_chars.push_back(r);
    cont_left = '0;
    seq_bytes = '0;
    acc       = '0;
  endfunction

  function void open_seq(logic [2:0] more, logic [30:0] bits);
    cont_left = more;
    seq_bytes = 3'd1;
    acc       = bits;
  endfunction

  // one accepted input word
  function void take_byte(logic [7:0] b);
    if (cont_left == 3'd0) begin
      casez (b)
        8'b0???????: push_char({23'd0, b}, 3'd1, ST_OK);
        8'b110?????: open_seq(3'd1, {26'd0, b[4:0]});
        8'b1110????: open_seq(3'd2, {27'd0, b[3:0]});
        8'b11110???: open_seq(3'd3, {28'd0, b[2:0]});
        8'b111110??: open_seq(3'd4, {29'd0, b[1:0]});
        8'b1111110?: open_seq(3'd5, {30'd0, b[0]});
        default:     push_char('0, 3'd1, ST_BAD_LEAD);
      endcase
    end else if (b[7:6] != 2'b10) begin
      push_char('0, seq_bytes + 3'd1, ST_BAD_CONT);
    end else begin
      acc       = {acc[24:0], b[5:0]};
      seq_bytes = seq_bytes + 3'd1;
      cont_left = cont_left - 3'd1;
      if (cont_left == 3'd0) push_char(acc, seq_bytes, ST_OK);
    end
  endfunction

  // one accepted result word
  function void check_char(logic [30:0] cp, logic [2:0] len, logic [1:0] st);
    dec_result_t want;
    if (pending_chars.size() == 0) begin
      $display("%0t: unexpected result cp=%h len=%0d status=%0d", $time, cp, len, st);
      mismatches++;
      return;
    end
    want = pending_chars.pop_front();
    if (cp !== want.code_point) begin
      $display("%0t: code_point expected %h actual %h", $time, want.code_point, cp);
      mismatches++;
    end
    if (len !== want.seq_length) begin
      $display("%0t: seq_length expected %0d actual %0d", $time, want.seq_length, len);
      mismatches++;
    end
    if (st !== want.status) begin
      $display("%0t: status expected %0d actual %0d", $time, want.status, st);
      mismatches++;
    end
    case (want.status)
      ST_OK:       chars_by_len[want.seq_length]++;
      ST_BAD_LEAD: lead_errs++;
      default:     cont_errs++;
    endcase
  endfunction
endclass

module tb;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [30:0] code_point;
  logic [2:0]  seq_length;
  logic [1:0]  status;

  decode_checker chk;
  bit            quiet = 1'b0;
  int            stall_left = 0;
  int            bytes_sent = 0;

  logic [7:0] warmup_bytes[$] = '{
    8'h00, 8'h7F, 8'h80, 8'hFE, 8'hFF,
    8'hC0, 8'h80,
    8'hE2, 8'h82, 8'hAC,
    8'hF7, 8'hBF, 8'hBF, 8'hBF,
    8'hF8, 8'h88, 8'h80, 8'h80, 8'h80,
    8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF,
    8'hE2, 8'h00,
    8'hC3, 8'hF0
  };

  utf8_stream_decoder_core u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .code_point (code_point),
    .seq_length (seq_length),
    .status     (status)
  );

  always #5 clk = ~clk;

  function automatic int pick_wait();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  // payload bits, biased toward all-zero and all-one content
  function automatic logic [7:0] pick_bits();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      chk.check_char(code_point, seq_length, status);
    if (rst || quiet) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left = pick_wait();
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chk.take_byte(b);
    bytes_sent++;
  endtask

  // n-byte sequence; break_at > 1 replaces that byte with a non-continuation
  task automatic send_seq(input int n, input int break_at);
    logic [7:0] b;
    b = pick_bits();
    case (n)
      1:       b = {1'b0, b[6:0]};
      2:       b = {3'b110, b[4:0]};
      3:       b = {4'b1110, b[3:0]};
      4:       b = {5'b11110, b[2:0]};
      5:       b = {6'b111110, b[1:0]};
      default: b = {7'b1111110, b[0]};
    endcase
    send_byte(b);
    for (int k = 2; k <= n; k++) begin
      if (k == break_at) begin
        b = 8'($urandom_range(0, 255));
        while (b[7:6] == 2'b10) b = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 5) == 0) b = 8'h00;
        send_byte(b);
        return;
      end
      b = pick_bits();
      send_byte({2'b10, b[5:0]});
    end
  endtask

  task automatic random_burst(input int target);
    int r;
    int n;
    while (bytes_sent < target) begin
      r = $urandom_range(0, 99);
      n = $urandom_range(1, 6);
      if (r < 12) send_byte(8'($urandom_range(0, 255)));
      else if (r < 25 && n > 1) send_seq(n, $urandom_range(2, n));
      else send_seq(n, 0);
    end
  endtask

  task automatic drain();
    while (chk.pending_chars.size() != 0) @(posedge clk);
  endtask

  initial begin
    chk = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (warmup_bytes[i]) send_byte(warmup_bytes[i]);

    random_burst(200);
    in_valid <= 1'b0;
    drain();

    quiet = 1'b1;
    random_burst(320);
    quiet = 1'b0;
    random_burst(450);

    in_valid <= 1'b0;
    quiet = 1'b1;
    drain();
    repeat (10) @(posedge clk);

    $display("summary: %0d bytes in; ok characters by length 1..6: %0d %0d %0d %0d %0d %0d",
             bytes_sent, chk.chars_by_len[1], chk.chars_by_len[2], chk.chars_by_len[3],
             chk.chars_by_len[4], chk.chars_by_len[5], chk.chars_by_len[6]);
    $display("summary: %0d invalid-lead and %0d bad-continuation reports, %0d mismatches",
             chk.lead_errs, chk.cont_errs, chk.mismatches);
    if (chk.mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", chk.pending_chars.size());
    $display("tb: errors");
    $finish;
  end

endmodule

// ----- utf8_stream_decoder_core.f -----
sv/u8d_pkg.sv
sv/u8d_step.sv
sv/utf8_stream_decoder_core.sv
test/tb.sv
